FILE: design/pgpg_pkg.sv
package pgpg_pkg;

  // Q1.15 unity
  localparam logic [15:0] Q_ONE = 16'd32768;

  // register indexes
  localparam logic [1:0] REG_STANCE = 2'd0;
  localparam logic [1:0] REG_DUTY   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_INIT   = 2'd3;

  // pipeline shape: products, sum, modulo steps, select, division steps
  localparam int MOD_STEPS = 33;
  localparam int DIV_STEPS = 15;
  localparam int LAT = 2 + MOD_STEPS + 1 + DIV_STEPS;

  typedef logic [15:0] lane_t;
  typedef logic [14:0] phase_t;

endpackage

FILE: design/pgpg_leg.sv
module pgpg_leg (
  input  logic            clk,
  input  logic            adv,
  input  logic [31:0]     t,
  input  pgpg_pkg::lane_t s,
  input  pgpg_pkg::lane_t d,
  input  pgpg_pkg::lane_t o,
  input  logic            init,
  output logic            st,
  output pgpg_pkg::phase_t ph
);
  import pgpg_pkg::*;

  logic [15:0] d_sat;
  logic [15:0] ratio;
  logic [30:0] lim;
  logic [30:0] rest;

  logic [46:0] p_td;
  logic [31:0] p_os;

  logic [15:0] mrem [0:MOD_STEPS];
  logic [32:0] mq   [0:MOD_STEPS];
  logic [14:0] mlow [0:MOD_STEPS];

  logic [30:0] r;
  logic [30:0] drem [0:DIV_STEPS];
  logic [30:0] dden [0:DIV_STEPS];
  logic [14:0] dq   [0:DIV_STEPS];
  logic        dsel [0:DIV_STEPS];

  // saturate duty and form the share owned by the initial state
  assign d_sat = (d > Q_ONE) ? Q_ONE : d;
  assign ratio = init ? d_sat : (Q_ONE - d_sat);
  assign lim   = 31'(32'(ratio) * 32'(s));
  assign rest  = 31'(32'(Q_ONE - ratio) * 32'(s));

  // products of time and offset
  always_ff @(posedge clk) begin
    if (adv) begin
      p_td <= 47'(48'(t) * 48'(d_sat));
      p_os <= 32'(s) * 32'(o);
    end
  end

  // sum; split into the part reduced modulo s and the low 15 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      mq[0]   <= 33'((48'(p_td) + 48'(p_os)) >> 15);
      mlow[0] <= p_td[14:0] + p_os[14:0];
      mrem[0] <= '0;
    end
  end

  // restoring modulo, one quotient bit a stage
  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [16:0] trial;
    assign trial = {mrem[j], mq[j][32]};
    always_ff @(posedge clk) begin
      if (adv) begin
        mrem[j+1] <= (trial >= 17'(s)) ? 16'(trial - 17'(s)) : trial[15:0];
        mq[j+1]   <= {mq[j][31:0], 1'b0};
        mlow[j+1] <= mlow[j];
      end
    end
  end

  assign r = {mrem[MOD_STEPS], mlow[MOD_STEPS]};

  // pick the share that holds the position
  always_ff @(posedge clk) begin
    if (adv) begin
      dsel[0] <= r < lim;
      drem[0] <= (r < lim) ? r : (r - lim);
      dden[0] <= (r < lim) ? lim : rest;
      dq[0]   <= '0;
    end
  end

  // restoring division for the 15-bit phase, one bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0] sh;
    assign sh = {drem[k], 1'b0};
    always_ff @(posedge clk) begin
      if (adv) begin
        drem[k+1] <= (sh >= 32'(dden[k])) ? 31'(sh - 32'(dden[k])) : sh[30:0];
        dq[k+1]   <= {dq[k][13:0], (sh >= 32'(dden[k]))};
        dden[k+1] <= dden[k];
        dsel[k+1] <= dsel[k];
      end
    end
  end

  // an empty period reports the opposite state at phase zero
  assign st = (s == '0) ? ~init : (dsel[DIV_STEPS] ? init : ~init);
  assign ph = (s == '0) ? '0 : dq[DIV_STEPS];

endmodule

FILE: design/periodic_gait_phase_generator_unit.sv
// Periodic gait phase generator.
// Input channel in_valid/in_ready carries time_ticks, the present time in
// ticks. Output channel out_valid/out_ready carries per-leg stance/swing state
// and a Q0.15 phase within that state, plus config_error when any active duty
// is zero.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data; index 0
// stance durations, 1 duty factors, 2 phase offsets, 3 initial states.
// Write it only while no request is in flight.
// The pipeline has LAT = 51 register stages: two of products and sum, 33 of
// bit-serial modulo of the scaled time by the stance duration, a select stage
// and 15 of phase division. One request is taken every cycle while the
// receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated. Bubbles are not squeezed
// out: the pipeline moves as one.
// Reset clears the configuration to zero and empties the pipeline.
module periodic_gait_phase_generator_unit #(
  parameter int NUM_LEGS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        leg0_state,
  output logic        leg1_state,
  output logic        leg2_state,
  output logic        leg3_state,
  output logic [14:0] leg0_phase,
  output logic [14:0] leg1_phase,
  output logic [14:0] leg2_phase,
  output logic [14:0] leg3_phase,
  output logic        config_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import pgpg_pkg::*;

  logic [63:0] stance_durations;
  logic [63:0] duty_factors;
  logic [63:0] phase_offsets;
  logic [3:0]  initial_states;
  logic [LAT-1:0] vld;
  logic adv;
  logic err;
  logic   st  [0:3];
  phase_t ph  [0:3];
  logic [3:0] dz;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stance_durations <= '0;
      duty_factors     <= '0;
      phase_offsets    <= '0;
      initial_states   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STANCE: stance_durations <= cfg_data;
        REG_DUTY:   duty_factors     <= cfg_data;
        REG_OFFSET: phase_offsets    <= cfg_data;
        REG_INIT:   initial_states   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // advance the pipeline unless the finished result is stalled
  assign adv      = ~vld[LAT-1] | out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  for (genvar k = 0; k < 4; k++) begin : g_leg
    if (k < NUM_LEGS) begin : g_on
      logic   lst;
      phase_t lph;
      pgpg_leg u_leg (
        .clk  (clk),
        .adv  (adv),
        .t    (time_ticks),
        .s    (stance_durations[16*k +: 16]),
        .d    (duty_factors[16*k +: 16]),
        .o    (phase_offsets[16*k +: 16]),
        .init (initial_states[k]),
        .st   (lst),
        .ph   (lph)
      );
      assign dz[k] = duty_factors[16*k +: 16] == '0;
      // a zero duty anywhere forces initial state at phase zero
      assign st[k] = err ? initial_states[k] : lst;
      assign ph[k] = err ? '0 : lph;
    end else begin : g_off
      assign dz[k] = 1'b0;
      assign st[k] = 1'b0;
      assign ph[k] = '0;
    end
  end

  assign err          = |dz;
  assign config_error = err;
  assign leg0_state   = st[0];
  assign leg1_state   = st[1];
  assign leg2_state   = st[2];
  assign leg3_state   = st[3];
  assign leg0_phase   = ph[0];
  assign leg1_phase   = ph[1];
  assign leg2_phase   = ph[2];
  assign leg3_phase   = ph[3];

endmodule

FILE: design/pgpg_checker.sv
module pgpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] leg0_phase,
  input logic [14:0] leg1_phase,
  input logic [14:0] leg2_phase,
  input logic [14:0] leg3_phase,
  input logic        config_error
);

  // empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // hold a stalled result: valid stays and the leg 0 and leg 1 phases are stable
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(leg0_phase) && $stable(leg1_phase))
    else $error("stalled result changed");

  // drop phases on a zero duty
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> leg0_phase == 15'd0 && leg1_phase == 15'd0
      && leg2_phase == 15'd0 && leg3_phase == 15'd0)
    else $error("phase nonzero with config error");

  // accept whenever the output is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

endmodule

bind periodic_gait_phase_generator_unit pgpg_checker u_pgpg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .leg0_phase   (leg0_phase),
  .leg1_phase   (leg1_phase),
  .leg2_phase   (leg2_phase),
  .leg3_phase   (leg3_phase),
  .config_error (config_error)
);
